@@ hdl/cled_pkg.sv @@
package cled_pkg;

    // Number of 8x8 modules in the chain (1 to 4).
    localparam int MODULES    = 4;
    localparam int MOD_W      = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int ADDR_W     = MOD_W + 3;
    localparam int RAM_DEPTH  = 1 << ADDR_W;
    localparam int ROWS_TOTAL = MODULES * 8;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Command codes.
    localparam logic [3:0] OP_PIX_ON   = 4'd0;
    localparam logic [3:0] OP_PIX_OFF  = 4'd1;
    localparam logic [3:0] OP_PIX_TGL  = 4'd2;
    localparam logic [3:0] OP_SHIFT_LR = 4'd3;
    localparam logic [3:0] OP_SHIFT_RL = 4'd4;
    localparam logic [3:0] OP_CLEAR    = 4'd5;
    localparam logic [3:0] OP_FILL     = 4'd6;
    localparam logic [3:0] OP_REFRESH  = 4'd7;
    localparam logic [3:0] OP_CTRL_WR  = 4'd8;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [MOD_W-1:0]  t_mod;

endpackage

@@ hdl/cled_ram.sv @@
module cled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cascaded_led_matrix_framebuffer_top.sv @@
// Channel   Direction  tdata (lowest bit up)                        tuser          tlast
// s_axis    in         pixel_x[4:0] pixel_y[7:5] reg_addr[11:8]      op[3:0]        -
//                      ctrl_data[19:12], zero pad [23:20]
// m_axis    out        slot_index[1:0] slot_addr[5:2]               frame_end[0]   last
//                      slot_data[13:6], zero pad [15:14]
//
// A pixel command reads, modifies and writes one row byte (S_PIX_RD, then S_PIX_WR).
// A shift reads and writes each of the 8 * MODULES row bytes in turn through the single
// read-modify-write path of the frame buffer RAM. Clear and fill write one byte per cycle.
// A refresh or control write gives MODULES * MODULES words, one per cycle while m_axis
// takes them; before each frame a refresh reads its row byte in S_RF_RD and S_RF_LD.
// Every command is taken in S_IDLE, the only state in which s_axis_tready is high.
// Reset marks every byte as zero at once through per-byte valid flags; no clearing pass.
// The output word register lets the last word wait while the next command is taken.
module cascaded_led_matrix_framebuffer_top
    import cled_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_x, pixel_y, reg_addr, ctrl_data
    input  logic [3:0]            s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot_index, slot_addr, slot_data
    output logic                  m_axis_tuser,   // frame_end
    output logic                  m_axis_tlast    // last
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PIX_RD = 4'd1;
    localparam logic [3:0] S_PIX_WR = 4'd2;
    localparam logic [3:0] S_SH_RD  = 4'd3;
    localparam logic [3:0] S_SH_WR  = 4'd4;
    localparam logic [3:0] S_SWEEP  = 4'd5;
    localparam logic [3:0] S_RF_RD  = 4'd6;
    localparam logic [3:0] S_RF_LD  = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    localparam t_mod  MOD_LAST = MOD_W'(MODULES - 1);
    localparam t_addr ROW_LAST = ADDR_W'(ROWS_TOTAL - 1);

    // Input word fields.
    logic [3:0] in_op;
    logic [4:0] in_x;
    logic [2:0] in_y;
    logic [3:0] in_addr;
    logic [7:0] in_data;

    assign in_op   = s_axis_tuser;
    assign in_x    = s_axis_tdata[4:0];
    assign in_y    = s_axis_tdata[7:5];
    assign in_addr = s_axis_tdata[11:8];
    assign in_data = s_axis_tdata[19:12];

    logic [3:0]     r_state, n_state;
    logic [3:0]     r_op;
    logic [2:0]     r_row, n_row;       // pixel row, refresh row or shift row
    t_mod           r_pmod;             // module of a pixel command
    logic [2:0]     r_bit;              // bit position within the byte, 7 - x mod 8
    t_mod           r_cnt, n_cnt;       // module count in a shift
    logic           r_carry, n_carry;
    t_addr          r_sweep, n_sweep;
    t_mod           r_d, n_d;           // frame number
    t_mod           r_s, n_s;           // slot number
    logic [7:0]     r_byte, n_byte;
    logic [3:0]     r_waddr;            // register address sent in the hit slot
    logic [RAM_DEPTH-1:0] r_valid;
    logic           r_rd_valid;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_fend;
    logic                  r_out_last;

    // RAM port.
    t_addr      ram_addr;
    logic       ram_we;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;
    logic [7:0] rd_byte;

    logic       in_accept;
    logic       out_free;
    logic       emit_word;
    t_mod       sh_mod;
    logic [7:0] pix_mask;

    cled_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // A byte never written since reset reads as zero.
    assign rd_byte   = r_rd_valid ? ram_rdata : BYTE_ZERO;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit_word = (r_state == S_EMIT) && out_free;
    assign sh_mod    = (r_op == OP_SHIFT_LR) ? r_cnt : MOD_W'(MOD_LAST - r_cnt);
    assign pix_mask  = 8'(1) << r_bit;

    assign s_axis_tready = (r_state == S_IDLE);

    // Address, write enable and write data of the frame buffer for each state.
    always_comb begin
        ram_addr  = {r_pmod, r_row};
        ram_we    = 1'b0;
        ram_wdata = rd_byte;
        unique case (r_state)
            S_PIX_RD: begin
                ram_addr = {r_pmod, r_row};
            end
            S_PIX_WR: begin
                ram_addr = {r_pmod, r_row};
                ram_we   = 1'b1;
                unique case (r_op)
                    OP_PIX_ON:  ram_wdata = rd_byte | pix_mask;
                    OP_PIX_OFF: ram_wdata = rd_byte & ~pix_mask;
                    default:    ram_wdata = rd_byte ^ pix_mask;
                endcase
            end
            S_SH_RD: begin
                ram_addr = {sh_mod, r_row};
            end
            S_SH_WR: begin
                ram_addr = {sh_mod, r_row};
                ram_we   = 1'b1;
                if (r_op == OP_SHIFT_LR) begin
                    ram_wdata = {r_carry, rd_byte[7:1]};
                end else begin
                    ram_wdata = {rd_byte[6:0], r_carry};
                end
            end
            S_SWEEP: begin
                ram_addr  = r_sweep;
                ram_we    = 1'b1;
                ram_wdata = (r_op == OP_FILL) ? BYTE_ONES : BYTE_ZERO;
            end
            S_RF_RD, S_RF_LD: begin
                ram_addr = {r_d, r_row};
            end
            default: begin
                ram_addr = {r_pmod, r_row};
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_cnt   = r_cnt;
        n_carry = r_carry;
        n_sweep = r_sweep;
        n_d     = r_d;
        n_s     = r_s;
        n_byte  = r_byte;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_row   = in_y;
                    n_cnt   = '0;
                    n_carry = 1'b0;
                    n_sweep = '0;
                    n_d     = '0;
                    n_s     = '0;
                    n_byte  = in_data;
                    unique case (in_op) inside
                        OP_PIX_ON, OP_PIX_OFF, OP_PIX_TGL: begin
                            if (4'(in_x[4:3]) < 4'(MODULES)) begin
                                n_state = S_PIX_RD;
                            end
                        end
                        OP_SHIFT_LR, OP_SHIFT_RL: begin
                            n_row   = '0;
                            n_state = S_SH_RD;
                        end
                        OP_CLEAR, OP_FILL: n_state = S_SWEEP;
                        OP_REFRESH:        n_state = S_RF_RD;
                        OP_CTRL_WR:        n_state = S_EMIT;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_PIX_RD: n_state = S_PIX_WR;
            S_PIX_WR: n_state = S_IDLE;
            S_SH_RD:  n_state = S_SH_WR;
            S_SH_WR: begin
                n_carry = (r_op == OP_SHIFT_LR) ? rd_byte[0] : rd_byte[7];
                n_state = S_SH_RD;
                if (r_cnt == MOD_LAST) begin
                    n_cnt   = '0;
                    n_carry = 1'b0;
                    n_row   = r_row + 3'd1;
                    if (r_row == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + MOD_W'(1);
                end
            end
            S_SWEEP: begin
                n_sweep = r_sweep + ADDR_W'(1);
                if (r_sweep == ROW_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_RF_RD: n_state = S_RF_LD;
            S_RF_LD: begin
                n_byte  = rd_byte;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_s == MOD_LAST) begin
                        n_s = '0;
                        if (r_d == MOD_LAST) begin
                            n_state = S_IDLE;
                        end else begin
                            n_d     = r_d + MOD_W'(1);
                            n_state = (r_op == OP_REFRESH) ? S_RF_RD : S_EMIT;
                        end
                    end else begin
                        n_s = r_s + MOD_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[ram_addr] <= 1'b1;
            end
            if (emit_word) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_cnt      <= n_cnt;
        r_carry    <= n_carry;
        r_sweep    <= n_sweep;
        r_d        <= n_d;
        r_s        <= n_s;
        r_byte     <= n_byte;
        r_rd_valid <= r_valid[ram_addr];
        if (in_accept) begin
            r_op    <= in_op;
            r_pmod  <= MOD_W'(in_x[4:3]);
            r_bit   <= 3'd7 - in_x[2:0];
            // A refresh sends the row number plus one as the register address.
            r_waddr <= (in_op == OP_REFRESH) ? 4'(in_y) + 4'd1 : in_addr;
        end
        if (emit_word) begin
            // Slot d of frame d carries the word; every other slot is a no-op.
            r_out_data <= {2'b00,
                           (r_s == r_d) ? r_byte : BYTE_ZERO,
                           (r_s == r_d) ? r_waddr : 4'd0,
                           2'(r_s)};
            r_out_fend <= (r_s == MOD_LAST);
            r_out_last <= (r_s == MOD_LAST) && (r_d == MOD_LAST);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_fend;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ tb/cled_word_checker.sv @@
module cled_word_checker
    import cled_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // pixel_x, pixel_y, reg_addr, ctrl_data
    input  logic [3:0]            i_s_tuser,   // op
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // slot_index, slot_addr, slot_data
    input  logic                  i_m_tuser,   // frame_end
    input  logic                  i_m_tlast,   // last
    output int                    o_fail_count,
    output int                    o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] slot_index;
        logic [3:0] slot_addr;
        logic [7:0] slot_data;
        logic       frame_end;
        logic       last;
    } t_chain_word;

    logic [7:0]  frame_bytes [ROWS_TOTAL];
    t_chain_word chain_words [$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    // One frame per module; in frame d only slot d carries the real word.
    task automatic queue_frames(input logic [3:0] addr, input logic [7:0] bytes [MODULES]);
        t_chain_word w;
        for (int d = 0; d < MODULES; d++) begin
            for (int s = 0; s < MODULES; s++) begin
                w.slot_index = 2'(s);
                w.slot_addr  = (s == d) ? addr : 4'd0;
                w.slot_data  = (s == d) ? bytes[d] : BYTE_ZERO;
                w.frame_end  = (s == MODULES - 1);
                w.last       = (s == MODULES - 1) && (d == MODULES - 1);
                chain_words.push_back(w);
            end
        end
    endtask

    task automatic apply_command(input logic [3:0] op, input logic [4:0] x,
                                 input logic [2:0] y, input logic [3:0] addr,
                                 input logic [7:0] data);
        logic [7:0] bytes [MODULES];
        logic [7:0] mask;
        int         idx;
        mask = 8'h80 >> x[2:0];
        idx  = int'(x >> 3) * 8 + int'(y);
        case (op)
            OP_PIX_ON: begin
                if ((x >> 3) < MODULES) frame_bytes[idx] = frame_bytes[idx] | mask;
            end
            OP_PIX_OFF: begin
                if ((x >> 3) < MODULES) frame_bytes[idx] = frame_bytes[idx] & ~mask;
            end
            OP_PIX_TGL: begin
                if ((x >> 3) < MODULES) frame_bytes[idx] = frame_bytes[idx] ^ mask;
            end
            OP_SHIFT_LR: begin
                // Highest module first, so the neighbour below is still unshifted.
                for (int m = MODULES - 1; m >= 0; m--) begin
                    for (int r = 0; r < 8; r++) begin
                        frame_bytes[m*8+r] = {(m != 0) ? frame_bytes[(m-1)*8+r][0] : 1'b0,
                                              frame_bytes[m*8+r][7:1]};
                    end
                end
            end
            OP_SHIFT_RL: begin
                for (int m = 0; m < MODULES; m++) begin
                    for (int r = 0; r < 8; r++) begin
                        frame_bytes[m*8+r] = {frame_bytes[m*8+r][6:0],
                                              (m != MODULES - 1) ? frame_bytes[(m+1)*8+r][7]
                                                                 : 1'b0};
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < ROWS_TOTAL; i++) frame_bytes[i] = BYTE_ZERO;
            end
            OP_FILL: begin
                for (int i = 0; i < ROWS_TOTAL; i++) frame_bytes[i] = BYTE_ONES;
            end
            OP_REFRESH: begin
                for (int m = 0; m < MODULES; m++) bytes[m] = frame_bytes[m*8+int'(y)];
                queue_frames(4'(y) + 4'd1, bytes);
            end
            OP_CTRL_WR: begin
                for (int m = 0; m < MODULES; m++) bytes[m] = data;
                queue_frames(addr, bytes);
            end
            default: ;
        endcase
    endtask

    task automatic check_word();
        t_chain_word want;
        t_chain_word got;
        got.slot_index = i_m_tdata[1:0];
        got.slot_addr  = i_m_tdata[5:2];
        got.slot_data  = i_m_tdata[13:6];
        got.frame_end  = i_m_tuser;
        got.last       = i_m_tlast;
        if (chain_words.size() == 0) begin
            $error("unexpected word: index %0d addr %0d data %0h", got.slot_index,
                   got.slot_addr, got.slot_data);
            fail_total++;
        end else begin
            want = chain_words.pop_front();
            if (got.slot_index !== want.slot_index) begin
                $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
                fail_total++;
            end
            if (got.slot_addr !== want.slot_addr) begin
                $error("slot_addr: expected %0d, actual %0d", want.slot_addr, got.slot_addr);
                fail_total++;
            end
            if (got.slot_data !== want.slot_data) begin
                $error("slot_data: expected %0h, actual %0h", want.slot_data, got.slot_data);
                fail_total++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
                fail_total++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                fail_total++;
            end
        end
    endtask

    // Commands are taken before words so that a word can never overtake its command.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS_TOTAL; i++) begin
                frame_bytes[i] = BYTE_ZERO;
            end
            chain_words.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                apply_command(i_s_tuser, i_s_tdata[4:0], i_s_tdata[7:5], i_s_tdata[11:8],
                              i_s_tdata[19:12]);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_word();
            end
        end
        o_words_pending <= chain_words.size();
    end

endmodule

@@ tb/tb_cascaded_led_matrix_framebuffer_top.sv @@
module tb_cascaded_led_matrix_framebuffer_top
    import cled_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes above the control write are unused and must be ignored.
    localparam logic [3:0] OP_LAST_CODE = 4'd15;

    localparam int RANDOM_ITEMS = 405;
    // A shift is the longest stretch without any word moving, so this leaves a very wide
    // margin over the slowest correct behaviour.
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // pixel_x, pixel_y, reg_addr, ctrl_data, zero pad
    logic [3:0]            s_axis_tuser;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // slot_index, slot_addr, slot_data, zero pad
    logic                  m_axis_tuser;   // frame_end
    logic                  m_axis_tlast;   // last

    int fail_count;
    int words_pending;
    int idle_cycles;
    // While calm is set neither side inserts any idle cycles.
    bit calm;

    cascaded_led_matrix_framebuffer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cled_word_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Presents one command and holds it until the block takes it. Valid is only
    // lowered when a gap is inserted, so back-to-back commands keep it high.
    task automatic send_command(input logic [3:0] op, input logic [4:0] x,
                                input logic [2:0] y, input logic [3:0] addr,
                                input logic [7:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tdata  <= {4'b0000, data, addr, y, x};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A random command, weighted towards pixel edits and refreshes so that the
    // buffer builds up interesting patterns before it is read back.
    task automatic send_random_command();
        int         pick;
        logic [3:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = 4'($urandom_range(OP_PIX_ON, OP_PIX_TGL));
        else if (pick < 55) op = 4'($urandom_range(OP_SHIFT_LR, OP_SHIFT_RL));
        else if (pick < 59) op = 4'($urandom_range(OP_CLEAR, OP_FILL));
        else if (pick < 82) op = OP_REFRESH;
        else if (pick < 95) op = OP_CTRL_WR;
        else                op = 4'($urandom_range(OP_CTRL_WR + 1, OP_LAST_CODE));
        send_command(op, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // Output back-pressure: short random stalls.
    initial begin
        m_axis_tready = 1'b1;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any cycle in which a word moves on either channel restarts the count.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PIX_ON;
        calm          = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A refresh straight after reset must show an empty buffer.
        send_command(OP_REFRESH, 5'd0, 3'd0, 4'd0, 8'h00);
        // Corner pixels and the pixels either side of the first module boundary.
        send_command(OP_PIX_ON, 5'd0, 3'd0, 4'd0, 8'h00);
        send_command(OP_PIX_ON, 5'd31, 3'd7, 4'd15, 8'hFF);
        send_command(OP_PIX_ON, 5'd7, 3'd3, 4'd0, 8'h00);
        send_command(OP_PIX_ON, 5'd8, 3'd3, 4'd0, 8'h00);
        send_command(OP_REFRESH, 5'd31, 3'd3, 4'd15, 8'hFF);
        // Shifts carry bits across module boundaries and drop them off the chain ends.
        send_command(OP_SHIFT_LR, 5'd0, 3'd0, 4'd0, 8'h00);
        send_command(OP_REFRESH, 5'd0, 3'd3, 4'd0, 8'h00);
        send_command(OP_SHIFT_RL, 5'd0, 3'd0, 4'd0, 8'h00);
        send_command(OP_REFRESH, 5'd0, 3'd7, 4'd0, 8'h00);
        // A double toggle must restore the pixel.
        send_command(OP_PIX_TGL, 5'd31, 3'd7, 4'd0, 8'h00);
        send_command(OP_PIX_TGL, 5'd31, 3'd7, 4'd0, 8'h00);
        send_command(OP_PIX_OFF, 5'd0, 3'd0, 4'd0, 8'h00);
        send_command(OP_REFRESH, 5'd0, 3'd0, 4'd0, 8'h00);
        // On a full buffer the zero fill at the vacated end of each shift is visible.
        send_command(OP_FILL, 5'd0, 3'd0, 4'd0, 8'h00);
        send_command(OP_SHIFT_LR, 5'd0, 3'd0, 4'd0, 8'h00);
        send_command(OP_REFRESH, 5'd0, 3'd7, 4'd0, 8'h00);
        send_command(OP_SHIFT_RL, 5'd0, 3'd0, 4'd0, 8'h00);
        send_command(OP_REFRESH, 5'd0, 3'd5, 4'd0, 8'h00);
        send_command(OP_CLEAR, 5'd31, 3'd7, 4'd15, 8'hFF);
        send_command(OP_REFRESH, 5'd0, 3'd2, 4'd0, 8'h00);
        // Control writes at both extremes of address and data.
        send_command(OP_CTRL_WR, 5'd0, 3'd0, 4'd15, 8'hFF);
        send_command(OP_CTRL_WR, 5'd31, 3'd7, 4'd0, 8'h00);
        // Unused codes must leave the buffer alone and produce no words.
        send_command(OP_CTRL_WR + 4'd1, 5'd31, 3'd7, 4'd15, 8'hFF);
        send_command(OP_LAST_CODE, 5'd31, 3'd7, 4'd15, 8'hFF);

        // Random part, with one stretch in the middle and the tail run without idling.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 150 && n < 200) || (n >= RANDOM_ITEMS - 40);
            send_random_command();
        end
        s_axis_tvalid <= 1'b0;

        // Drain every predicted word, then give the block time to show stray words.
        while (words_pending != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cled_pkg.sv
hdl/cled_ram.sv
hdl/cascaded_led_matrix_framebuffer_top.sv
tb/cled_word_checker.sv
tb/tb_cascaded_led_matrix_framebuffer_top.sv
